### sv/nss_pkg.sv
// Shared types, constants and helpers for the NFA state set stepper.
// No dependencies; every other file imports this package.
package nss_pkg;

	// Sizes of the automaton.
	localparam int NUM_STATES  = 8;
	localparam int NUM_SYMBOLS = 256;

	// Field widths fixed by the item format.
	localparam int SYM_W      = 8;
	localparam int STATE_W    = 3;
	localparam int SET_W      = 8;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 1;

	// Index widths derived from the sizes.
	localparam int STATE_IDX_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int SYM_IDX_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

	typedef logic [NUM_STATES-1:0] set_t;

	typedef enum logic [1:0] {
		OP_RESTART = 2'd0,
		OP_STEP    = 2'd1,
		OP_ADD     = 2'd2,
		OP_MARK    = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_INDEX = 1'b0,
		CFG_ACCEPT_MASK = 1'b1
	} cfg_idx_t;

	// Write command for the successor row slices held in the cells.
	typedef struct packed {
		logic                   en;
		logic                   fresh;
		logic [SYM_IDX_W-1:0]   addr;
		logic [STATE_W-1:0]     from_state;
		logic [STATE_IDX_W-1:0] to_idx;
	} row_wr_t;

	// True when the symbol lies inside the configured alphabet range.
	function automatic logic sym_in_range(input logic [SYM_W-1:0] s);
		logic [SYM_W:0] lim;
		lim = (SYM_W+1)'(NUM_SYMBOLS);
		return ({1'b0, s} < lim);
	endfunction

	// True when the state number names an existing state.
	function automatic logic state_in_range(input logic [STATE_W-1:0] s);
		logic [STATE_W:0] lim;
		lim = (STATE_W+1)'(NUM_STATES);
		return ({1'b0, s} < lim);
	endfunction

endpackage

### sv/nss_ifs.sv
// Channel interfaces of the NFA state set stepper: items, results, configuration.
// Depends on nss_pkg.
interface nss_in_if import nss_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [SYM_W-1:0]   symbol;
	logic [STATE_W-1:0] from_state;
	logic [STATE_W-1:0] to_state;

	modport source (output valid, opcode, symbol, from_state, to_state, input ready);
	modport sink (input valid, opcode, symbol, from_state, to_state, output ready);
endinterface

interface nss_out_if import nss_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SET_W-1:0] active_states;
	logic             accepted;
	logic             symbol_known;

	modport source (output valid, active_states, accepted, symbol_known, input ready);
	modport sink (input valid, active_states, accepted, symbol_known, output ready);
endinterface

interface nss_cfg_if import nss_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/nss_symtab.sv
// Per-symbol flags: alphabet membership and successor row written-once marks.
// Depends on nss_pkg.
module nss_symtab import nss_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [SYM_IDX_W-1:0] addr,
	input  logic                 sym_ok,
	input  logic                 add_en,
	input  logic                 mark_en,
	output logic                 row_fresh,
	output logic                 known_s1,
	output logic                 row_vld_s1
);

	logic [NUM_SYMBOLS-1:0] row_vld_q;
	logic [NUM_SYMBOLS-1:0] alpha_q;

	// A row that was never written reads as all zeros through its mark.
	assign row_fresh = !row_vld_q[addr];

	// Flags are set by add and mark beats and cleared only by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			alpha_q   <= '0;
		end else begin
			if (add_en) begin
				row_vld_q[addr] <= 1'b1;
			end
			if (mark_en) begin
				alpha_q[addr] <= 1'b1;
			end
		end
	end

	// Look up the flags of the accepted beat's symbol for the next stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			known_s1   <= sym_ok && alpha_q[addr];
			row_vld_s1 <= row_vld_q[addr];
		end
	end

endmodule

### sv/nss_cell.sv
// One state cell: its active bit, its slice of every successor row, and one
// link of the OR chain that builds the next active set. Depends on nss_pkg.
module nss_cell import nss_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [STATE_W-1:0]   cell_idx,
	input  logic                 accept,
	input  logic [SYM_IDX_W-1:0] rd_addr,
	input  row_wr_t              wr,
	input  logic                 row_vld_s1,
	input  logic                 load,
	input  logic                 next_bit,
	input  set_t                 acc_in,
	output set_t                 acc_out,
	output logic                 active
);

	set_t mem [NUM_SYMBOLS];
	set_t row_s1;
	logic active_q;
	logic is_from;

	assign is_from = (wr.from_state == cell_idx);
	assign active  = active_q;

	// Successors of this state join the set handed down the chain.
	assign acc_out = acc_in | ((active_q && row_vld_s1) ? row_s1 : '0);

	// Row slice storage: the first add to a row writes the whole row,
	// later adds set a single bit in the source state's slice.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			if (wr.fresh) begin
				mem[wr.addr] <= is_from ? (set_t'(1) << wr.to_idx) : '0;
			end else if (is_from) begin
				mem[wr.addr][wr.to_idx] <= 1'b1;
			end
		end
		if (accept) begin
			row_s1 <= mem[rd_addr];
		end
	end

	// Active bit; state zero is the start state after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= (cell_idx == '0);
		end else if (load) begin
			active_q <= next_bit;
		end
	end

endmodule

### sv/nfa_state_set_stepper.sv
// NFA state set stepper: bit-parallel NFA simulation, one item per beat.
// Two register stages: an item enters stage one when accepted and its result enters the output
// register when that is free. Throughput: one item per cycle unless the output stalls; the successor
// row read is registered at acceptance and the cell OR chain resolves the next set from stage one.
// Reset: active set holds only state 0, no transitions, empty alphabet,
// start_index and accept_mask zero; items are accepted right after reset.
module nfa_state_set_stepper import nss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	nss_in_if.sink    item_in,
	nss_out_if.source result_out,
	nss_cfg_if.sink   cfg
);

	logic [STATE_W-1:0] start_index_q;
	logic [SET_W-1:0]   accept_mask_q;

	logic                 accept;
	op_t                  op_in;
	logic [SYM_IDX_W-1:0] addr;
	logic                 sym_ok;
	logic                 add_en;
	logic                 mark_en;
	logic                 row_fresh;
	row_wr_t              wr;

	logic valid_s1;
	op_t  op_s1;
	logic known_s1;
	logic row_vld_s1;

	logic load_out;
	logic advance;
	set_t acc [NUM_STATES+1];
	set_t cur_set;
	set_t start_set;
	set_t new_set;

	logic             out_valid_q;
	logic [SET_W-1:0] active_states_q;
	logic             accepted_q;
	logic             known_q;

	// Configuration registers take every write beat.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_index_q <= '0;
			accept_mask_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_START_INDEX: start_index_q <= cfg.data[STATE_W-1:0];
				CFG_ACCEPT_MASK: accept_mask_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input decode: table writes happen at the accepting edge.
	assign accept  = item_in.valid && item_in.ready;
	assign op_in   = op_t'(item_in.opcode);
	assign addr    = item_in.symbol[SYM_IDX_W-1:0];
	assign sym_ok  = sym_in_range(item_in.symbol);
	assign add_en  = accept && (op_in == OP_ADD) && sym_ok
		&& state_in_range(item_in.from_state) && state_in_range(item_in.to_state);
	assign mark_en = accept && (op_in == OP_MARK) && sym_ok;

	always_comb begin
		wr.en         = add_en;
		wr.fresh      = row_fresh;
		wr.addr       = addr;
		wr.from_state = item_in.from_state;
		wr.to_idx     = item_in.to_state[STATE_IDX_W-1:0];
	end

	nss_symtab u_symtab (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.addr       (addr),
		.sym_ok     (sym_ok),
		.add_en     (add_en),
		.mark_en    (mark_en),
		.row_fresh  (row_fresh),
		.known_s1   (known_s1),
		.row_vld_s1 (row_vld_s1)
	);

	// Stage one holds the beat while its row slices sit in the cells.
	assign load_out      = !out_valid_q || result_out.ready;
	assign advance       = valid_s1 && load_out;
	assign item_in.ready = !valid_s1 || load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_in;
		end
	end

	// Row of state cells; the OR chain runs from cell zero upward.
	assign acc[0] = '0;

	for (genvar g = 0; g < NUM_STATES; g++) begin : g_cell
		nss_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_idx   (STATE_W'(g)),
			.accept     (accept),
			.rd_addr    (addr),
			.wr         (wr),
			.row_vld_s1 (row_vld_s1),
			.load       (advance),
			.next_bit   (new_set[g]),
			.acc_in     (acc[g]),
			.acc_out    (acc[g+1]),
			.active     (cur_set[g])
		);
	end

	// Next active set for the beat leaving stage one.
	assign start_set = state_in_range(start_index_q) ? (set_t'(1) << start_index_q) : '0;

	always_comb begin
		case (op_s1)
			OP_RESTART: new_set = start_set;
			OP_STEP:    new_set = known_s1 ? acc[NUM_STATES] : cur_set;
			default:    new_set = cur_set;
		endcase
	end

	// Output register decouples the result side from the cells.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			active_states_q <= SET_W'(new_set);
			accepted_q      <= |(new_set & accept_mask_q[NUM_STATES-1:0]);
			known_q         <= (op_s1 == OP_STEP) && known_s1;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.active_states = active_states_q;
	assign result_out.accepted      = accepted_q;
	assign result_out.symbol_known  = known_q;

endmodule

### dv/testbench.sv
// Self-checking testbench for the NFA state set stepper: directed and random item streams.
// Depends on nss_pkg, the channel interfaces in nss_ifs.sv and the stepper with its submodules.
module testbench import nss_pkg::*; ();

	localparam int CYCLE_LIMIT = 800000;
	localparam int POOL_SIZE   = 16;

	// Expected content of one result beat.
	typedef struct packed {
		logic [SET_W-1:0] states;
		logic             acc;
		logic             known;
	} outcome_t;

	logic clk;
	logic arst_n;

	nss_in_if  item_if ();
	nss_out_if res_if ();
	nss_cfg_if cfg_if ();

	nfa_state_set_stepper uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_if),
		.result_out (res_if),
		.cfg        (cfg_if)
	);

	// Shadow copy of the automaton and its registers.
	set_t             cur_set;
	set_t             succ_tab [NUM_SYMBOLS][NUM_STATES];
	bit               in_alpha [NUM_SYMBOLS];
	logic [STATE_W-1:0] start_reg;
	logic [SET_W-1:0]   accept_reg;

	outcome_t expected_outcomes [$];

	int  errors;
	int  n_items;
	int  n_known_steps;
	int  n_checked;
	int  n_cfg_writes;
	int  cycle_count;
	int  stall_left;
	bit  no_idle;
	logic [SYM_W-1:0] sym_pool [POOL_SIZE];

	// Free-running clock, period 10.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Gap length: mostly zero or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Set loaded by a restart; empty when the start number names no state.
	function automatic set_t start_set_of(input logic [STATE_W-1:0] idx);
		if (int'(idx) >= NUM_STATES)
			return '0;
		return set_t'(1) << idx;
	endfunction

	// Clear the shadow automaton to its state after reset.
	task automatic clear_automaton();
		int s;
		int q;
		for (s = 0; s < NUM_SYMBOLS; s++) begin
			in_alpha[s] = 1'b0;
			for (q = 0; q < NUM_STATES; q++)
				succ_tab[s][q] = '0;
		end
		start_reg  = '0;
		accept_reg = '0;
		cur_set    = start_set_of('0);
	endtask

	// Advance the shadow automaton by one item and form the expected result.
	task automatic advance_automaton(input op_t op, input logic [SYM_W-1:0] sym,
		input logic [STATE_W-1:0] src, input logic [STATE_W-1:0] dst, output outcome_t res);
		set_t nxt;
		logic known;
		bit   sym_ok;
		int   q;
		known  = 1'b0;
		sym_ok = int'(sym) < NUM_SYMBOLS;
		case (op)
			OP_RESTART: begin
				cur_set = start_set_of(start_reg);
			end
			OP_STEP: begin
				// Unknown symbols leave the set alone; known ones take the union of successors.
				if (sym_ok && in_alpha[sym]) begin
					known = 1'b1;
					nxt = '0;
					for (q = 0; q < NUM_STATES; q++)
						if (cur_set[q])
							nxt |= succ_tab[sym][q];
					cur_set = nxt;
					n_known_steps++;
				end
			end
			OP_ADD: begin
				if (sym_ok && int'(src) < NUM_STATES && int'(dst) < NUM_STATES)
					succ_tab[sym][src][dst] = 1'b1;
			end
			default: begin
				if (sym_ok)
					in_alpha[sym] = 1'b1;
			end
		endcase
		res.states = SET_W'(cur_set);
		res.acc    = |(SET_W'(cur_set) & accept_reg);
		res.known  = known;
	endtask

	// Send one item beat after a random gap unless no_idle is set; the expectation is queued at acceptance.
	task automatic send_item(input op_t op, input logic [SYM_W-1:0] sym,
		input logic [STATE_W-1:0] src, input logic [STATE_W-1:0] dst);
		int gap;
		outcome_t res;
		gap = no_idle ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_if.valid      <= 1'b1;
		item_if.opcode     <= op;
		item_if.symbol     <= sym;
		item_if.from_state <= src;
		item_if.to_state   <= dst;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		advance_automaton(op, sym, src, dst, res);
		expected_outcomes.push_back(res);
		n_items++;
	endtask

	// Stop sending and wait until every expected result has arrived.
	task automatic wait_for_results();
		@(negedge clk);
		item_if.valid <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register over the configuration channel; the block must be idle.
	task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			CFG_START_INDEX: start_reg  = value[STATE_W-1:0];
			default:         accept_reg = value;
		endcase
		n_cfg_writes++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Right after reset: empty alphabet, start state 0, nothing accepts.
	task automatic test_after_reset();
		send_item(OP_STEP, 8'h00, 3'd0, 3'd0);
		send_item(OP_RESTART, 8'hFF, 3'd7, 3'd7);
		send_item(OP_STEP, 8'hFF, 3'd7, 3'd0);
		wait_for_results();
	endtask

	// A small hand-built automaton touching every opcode and the field extremes.
	task automatic test_directed_automaton();
		write_register(CFG_START_INDEX, 8'h00);
		write_register(CFG_ACCEPT_MASK, 8'h80);
		send_item(OP_MARK, 8'h00, 3'd0, 3'd0);
		send_item(OP_MARK, 8'hFF, 3'd7, 3'd7);
		send_item(OP_MARK, 8'hAA, 3'd0, 3'd7);
		send_item(OP_ADD, 8'h00, 3'd0, 3'd7);
		// Adding the same transition twice changes nothing.
		send_item(OP_ADD, 8'h00, 3'd0, 3'd7);
		send_item(OP_ADD, 8'hFF, 3'd7, 3'd0);
		send_item(OP_ADD, 8'hFF, 3'd7, 3'd3);
		send_item(OP_ADD, 8'hAA, 3'd3, 3'd5);
		send_item(OP_ADD, 8'h00, 3'd5, 3'd5);
		send_item(OP_RESTART, 8'h00, 3'd0, 3'd0);
		send_item(OP_STEP, 8'h00, 3'd0, 3'd0);
		send_item(OP_STEP, 8'hFF, 3'd0, 3'd0);
		send_item(OP_STEP, 8'hAA, 3'd0, 3'd0);
		// A symbol outside the alphabet keeps the set.
		send_item(OP_STEP, 8'h55, 3'd0, 3'd0);
		send_item(OP_STEP, 8'h00, 3'd0, 3'd0);
		// States with no matching transition drop out, leaving an empty set.
		send_item(OP_STEP, 8'hFF, 3'd0, 3'd0);
		send_item(OP_STEP, 8'h00, 3'd0, 3'd0);
		wait_for_results();
		// Upper data bits of the start register are dropped; it applies at the next restart.
		write_register(CFG_START_INDEX, 8'hFF);
		write_register(CFG_ACCEPT_MASK, 8'hFF);
		send_item(OP_STEP, 8'h55, 3'd7, 3'd7);
		send_item(OP_RESTART, 8'h00, 3'd0, 3'd0);
		send_item(OP_STEP, 8'hFF, 3'd0, 3'd0);
		wait_for_results();
	endtask

	// One random phase: new register settings, then a stream over a small symbol pool.
	task automatic test_random_phase(input int count, input logic [STATE_W-1:0] start,
		input logic [SET_W-1:0] mask, input bit burst);
		int i;
		int r;
		op_t op;
		logic [SYM_W-1:0] sym;
		wait_for_results();
		write_register(CFG_START_INDEX, {5'($urandom), start});
		write_register(CFG_ACCEPT_MASK, mask);
		for (i = 0; i < POOL_SIZE; i++)
			sym_pool[i] = 8'($urandom_range(0, 255));
		no_idle = burst;
		send_item(OP_RESTART, 8'($urandom), 3'($urandom), 3'($urandom));
		for (i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				op = OP_RESTART;
			else if (r < 62)
				op = OP_STEP;
			else if (r < 85)
				op = OP_ADD;
			else
				op = OP_MARK;
			// Mostly pool symbols so that steps meet real transitions.
			if ($urandom_range(0, 9) == 0)
				sym = 8'($urandom_range(0, 255));
			else
				sym = sym_pool[$urandom_range(0, POOL_SIZE - 1)];
			send_item(op, sym, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
		end
		no_idle = 1'b0;
	endtask

	// Result sink with random stalls outside burst phases, most short and a few long.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_if.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap();
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin : check_result
		outcome_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_outcomes.size() == 0) begin
				$display("%0t: result beat with nothing expected, got active_states %h",
					$time, res_if.active_states);
				errors++;
			end else begin
				want = expected_outcomes.pop_front();
				n_checked++;
				if (res_if.active_states !== want.states) begin
					$display("%0t: active_states expected %h got %h",
						$time, want.states, res_if.active_states);
					errors++;
				end
				if (res_if.accepted !== want.acc) begin
					$display("%0t: accepted expected %b got %b",
						$time, want.acc, res_if.accepted);
					errors++;
				end
				if (res_if.symbol_known !== want.known) begin
					$display("%0t: symbol_known expected %b got %b",
						$time, want.known, res_if.symbol_known);
					errors++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding",
				cycle_count, expected_outcomes.size());
			$display("simulation failed");
			$finish;
		end
	end

	// Reset, then the tests in turn, then the verdict.
	initial begin
		errors        = 0;
		n_items       = 0;
		n_known_steps = 0;
		n_checked     = 0;
		n_cfg_writes  = 0;
		cycle_count   = 0;
		stall_left    = 0;
		no_idle       = 1'b0;
		arst_n        = 1'b0;
		item_if.valid      = 1'b0;
		item_if.opcode     = OP_RESTART;
		item_if.symbol     = '0;
		item_if.from_state = '0;
		item_if.to_state   = '0;
		res_if.ready  = 1'b0;
		cfg_if.valid  = 1'b0;
		cfg_if.index  = CFG_START_INDEX;
		cfg_if.data   = '0;
		clear_automaton();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		test_directed_automaton();
		test_random_phase(210, 3'd0, 8'h00, 1'b0);
		test_random_phase(210, 3'd7, 8'hFF, 1'b0);
		test_random_phase(210, 3'd0, 8'h01, 1'b0);
		test_random_phase(210, 3'($urandom), 8'($urandom), 1'b1);
		test_random_phase(210, 3'($urandom), 8'($urandom), 1'b0);
		test_random_phase(210, 3'd7, 8'h80, 1'b0);
		test_random_phase(210, 3'($urandom), 8'($urandom), 1'b1);
		test_random_phase(210, 3'($urandom), 8'($urandom), 1'b0);

		wait_for_results();
		repeat (10) @(posedge clk);
		errors += expected_outcomes.size();

		$display("Sent %0d items (%0d steps on known symbols) and checked %0d results",
			n_items, n_known_steps, n_checked);
		$display("across %0d register writes, with %0d mismatches", n_cfg_writes, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
sv/nss_pkg.sv
sv/nss_ifs.sv
sv/nss_symtab.sv
sv/nss_cell.sv
sv/nfa_state_set_stepper.sv
dv/testbench.sv
